// ===== src/gwrd_pkg.sv =====
// shared types, constants and direction codes for the grid walk revisit detector
package gwrd_pkg;

    localparam int COORD_BITS = 7;
    localparam int GRID_ROWS  = 1 << COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        row_t;
    typedef logic [GRID_ROWS-1:0]         word_t;

    localparam coord_t COORD_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
    localparam coord_t COORD_MIN = coord_t'(-(1 << (COORD_BITS - 1)));

    // direction characters
    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_W = 8'h57;
    localparam logic [7:0] CHAR_E = 8'h45;

    // one step handed from the front stage to the check stage
    typedef struct packed {
        logic   move;
        row_t   row;
        row_t   col;
        logic   last;
        logic   ovf;
        coord_t pos_a;
        coord_t pos_b;
    } issue_t;

endpackage

// ===== src/gwrd_row_ram.sv =====
// bitmap memory: one row of the grid per word, registered read
module gwrd_row_ram
    import gwrd_pkg::*;
(
    input  logic  clk,
    input  logic  rd_en,
    input  row_t  rd_addr,
    output word_t rd_data,
    input  logic  wr_en,
    input  row_t  wr_addr,
    input  word_t wr_data
);

    word_t mem [GRID_ROWS];
    word_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/gwrd_front.sv =====
// front stage: decodes the character, moves the position and tracks overflow
module gwrd_front
    import gwrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] step_char,
    input  logic       last_step,
    input  logic       frozen,
    output issue_t     issue
);

    coord_t coord_a_reg, coord_a_next;
    coord_t coord_b_reg, coord_b_next;
    logic   ovf_reg, ovf_next;

    logic   inc_a, dec_a, inc_b, dec_b;
    logic   is_move, out_of_window, step_ok;
    coord_t na, nb, pos_a, pos_b;
    logic   ovf_now;

    // direction decode
    always_comb
    begin
        inc_a = 1'b0;
        dec_a = 1'b0;
        inc_b = 1'b0;
        dec_b = 1'b0;
        case (step_char)
            CHAR_N:  inc_a = 1'b1;
            CHAR_S:  dec_a = 1'b1;
            CHAR_W:  inc_b = 1'b1;
            CHAR_E:  dec_b = 1'b1;
            default: ;
        endcase
    end

    // target cell and window check
    always_comb
    begin
        is_move = inc_a | dec_a | inc_b | dec_b;
        na = coord_a_reg + (inc_a ? coord_t'(1) : (dec_a ? coord_t'(-1) : coord_t'(0)));
        nb = coord_b_reg + (inc_b ? coord_t'(1) : (dec_b ? coord_t'(-1) : coord_t'(0)));
        out_of_window = (inc_a && coord_a_reg == COORD_MAX)
                     || (dec_a && coord_a_reg == COORD_MIN)
                     || (inc_b && coord_b_reg == COORD_MAX)
                     || (dec_b && coord_b_reg == COORD_MIN);
        step_ok = is_move && !frozen && !out_of_window;
        pos_a   = step_ok ? na : coord_a_reg;
        pos_b   = step_ok ? nb : coord_b_reg;
        ovf_now = ovf_reg | (is_move && !frozen && out_of_window);
    end

    // word passed to the check stage
    always_comb
    begin
        issue.move  = step_ok;
        issue.row   = row_t'(na);
        issue.col   = row_t'(nb);
        issue.last  = last_step;
        issue.ovf   = ovf_now;
        issue.pos_a = pos_a;
        issue.pos_b = pos_b;
    end

    // position update, cleared after the last word of a path
    always_comb
    begin
        coord_a_next = coord_a_reg;
        coord_b_next = coord_b_reg;
        ovf_next     = ovf_reg;
        if (accept)
        begin
            if (last_step)
            begin
                coord_a_next = '0;
                coord_b_next = '0;
                ovf_next     = 1'b0;
            end
            else
            begin
                coord_a_next = pos_a;
                coord_b_next = pos_b;
                ovf_next     = ovf_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_a_reg <= '0;
            coord_b_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            coord_a_reg <= coord_a_next;
            coord_b_reg <= coord_b_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

// ===== src/grid_walk_revisit_detector_unit.sv =====
// Grid walk revisit detector: follows a path of direction characters on a
// bounded grid and flags the first revisit of a cell.
//
// Input channel (in_valid/in_ready): one character per word with last_step
// marking the end of a path. Output channel (out_valid/out_ready): one result
// word per input word, in order, carrying the flags, the position after the
// step and path_done as an echo of last_step.
// An accepted word passes the check stage and then the output register
// before out_valid rises. One word is taken per cycle while the receiver
// keeps up: the front stage moves the position at acceptance and starts a
// read of the grid row, the check stage then tests the cell and writes
// the row back, forwarding the previous write when the same row is read back.
// Per-row valid flags cleared together at the end of a path stand in for
// clearing the bitmap, so a new path can follow the last word directly.
// Reset clears position, flags and row valid bits; no clearing pass is needed
// and the block takes words right after reset. A stalled receiver holds the
// output register and in_ready drops once the check stage is full too.
module grid_walk_revisit_detector_unit
    import gwrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] step_char,
    input  logic       last_step,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       crossed,
    output logic       overflow,
    output coord_t     pos_a,
    output coord_t     pos_b,
    output logic       path_done
);

    logic   s1_valid_reg, s1_valid_next;
    issue_t s1_reg;
    logic   fwd_hit_reg;
    word_t  fwd_word_reg;
    logic   crossed_reg, crossed_next;
    word_t  rowv_reg, rowv_next;

    logic   out_valid_reg, out_valid_next;
    logic   out_crossed_reg, out_overflow_reg, out_done_reg;
    coord_t out_pos_a_reg, out_pos_b_reg;

    issue_t issue;
    word_t  rd_data;
    logic   accept, s1_adv, frozen;
    word_t  row_word, wr_word;
    logic   row_live, origin, hit, crossed_s1, wr_en;

    // pipeline flow
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // front stage
    gwrd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .step_char (step_char),
        .last_step (last_step),
        .frozen    (frozen),
        .issue     (issue)
    );

    // grid bitmap
    gwrd_row_ram u_ram
    (
        .clk     (clk),
        .rd_en   (accept && issue.move),
        .rd_addr (issue.row),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.row),
        .wr_data (wr_word)
    );

    // cell check with forwarding of the previous row write
    always_comb
    begin
        row_word   = fwd_hit_reg ? fwd_word_reg : rd_data;
        row_live   = rowv_reg[s1_reg.row];
        origin     = (s1_reg.row == '0) && (s1_reg.col == '0);
        hit        = s1_reg.move && (origin || (row_live && row_word[s1_reg.col]));
        crossed_s1 = crossed_reg | hit;
        wr_en      = s1_adv && s1_reg.move && !hit && !s1_reg.last;
        wr_word    = (row_live ? row_word : '0) | (word_t'(1) << s1_reg.col);
    end

    // walk freezes once a crossing is known, a new path starts unfrozen
    assign frozen = s1_valid_reg ? (!s1_reg.last && crossed_s1) : crossed_reg;

    // next state of the check stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        crossed_next  = crossed_reg;
        rowv_next     = rowv_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            crossed_next  = s1_reg.last ? 1'b0 : crossed_s1;
            if (s1_reg.last)
            begin
                rowv_next = '0;
            end
            else if (wr_en)
            begin
                rowv_next[s1_reg.row] = 1'b1;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            crossed_reg  <= 1'b0;
            rowv_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            crossed_reg  <= crossed_next;
            rowv_reg     <= rowv_next;
        end
    end

    // check stage payload and forwarding capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= issue;
            fwd_hit_reg  <= wr_en && (s1_reg.row == issue.row);
            fwd_word_reg <= wr_word;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_crossed_reg  <= crossed_s1;
            out_overflow_reg <= s1_reg.ovf;
            out_pos_a_reg    <= s1_reg.pos_a;
            out_pos_b_reg    <= s1_reg.pos_b;
            out_done_reg     <= s1_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign crossed   = out_crossed_reg;
    assign overflow  = out_overflow_reg;
    assign pos_a     = out_pos_a_reg;
    assign pos_b     = out_pos_b_reg;
    assign path_done = out_done_reg;

endmodule
